// File: rtl/irc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_pkg: shared types and constants for the integer radix converter
// Holds the digit and radix widths, the radix limits, the controller states
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package irc_pkg;

    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int OUT_TDATA_W = 8;
    localparam int STEP_BITS   = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic rd_start;
        logic rd_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

// File: rtl/integer_radix_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_radix_converter_top: integer to radix-2..16 digit stream
// Converts one unsigned integer per input word into its digits in the
// configured radix, most significant digit first, one output word per digit.
// ----------------------------------------------------------------------------
// Each digit of an input word is produced by the divider, which retires eight
// quotient bits per cycle, and is played back by one read of the digit store
// per output word. A new input word is taken as soon as the last digit sits in
// the output register. Radix values below 2 act as 2 and values above 16 act
// as 16; a zero input gives the single digit 0.
module integer_radix_converter_top #(
    parameter  int VALUE_BITS = 31,
    localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_TDATA_W-1:0]             s_axis_tdata,   // value
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [irc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // digit
    output logic                              m_axis_tlast,
    input  logic                              cfg_wr_en,
    input  logic [irc_pkg::RADIX_W-1:0]       cfg_wr_data
);

    irc_pkg::cmd_t               cmd;
    irc_pkg::status_t            st;
    logic [irc_pkg::DIGIT_W-1:0] digit;

    irc_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    irc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_value    (s_axis_tdata[VALUE_BITS-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (m_axis_tvalid),
        .out_digit   (digit),
        .out_last    (m_axis_tlast),
        .out_ready   (m_axis_tready)
    );

    assign m_axis_tdata = irc_pkg::OUT_TDATA_W'(digit);

endmodule

// File: rtl/irc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; the read data holds until the
// next read.
// ----------------------------------------------------------------------------
module irc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 31
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/irc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_datapath: divider, digit store and output register
// Divides the running quotient by the radix eight bits a cycle, stores each
// remainder as a digit and plays the digits back most significant first.
// ----------------------------------------------------------------------------
module irc_datapath #(
    parameter int VALUE_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  irc_pkg::cmd_t                 cmd,
    output irc_pkg::status_t              st,
    input  logic [VALUE_BITS-1:0]         in_value,
    input  logic                          cfg_wr_en,
    input  logic [irc_pkg::RADIX_W-1:0]   cfg_wr_data,
    output logic                          out_valid,
    output logic [irc_pkg::DIGIT_W-1:0]   out_digit,
    output logic                          out_last,
    input  logic                          out_ready
);

    localparam int DIV_CYCLES = (VALUE_BITS + irc_pkg::STEP_BITS - 1) / irc_pkg::STEP_BITS;
    localparam int DIV_BITS   = DIV_CYCLES * irc_pkg::STEP_BITS;
    localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W     = $clog2(VALUE_BITS);

    logic [irc_pkg::RADIX_W-1:0] radix_reg, radix_next;
    logic [DIV_BITS-1:0]         quot_reg, quot_next, quot_step;
    logic [irc_pkg::DIGIT_W-1:0] rem_reg, rem_next, rem_step;
    logic [DCNT_W-1:0]           dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]            count_reg, count_next, count_dec;
    logic [ADDR_W-1:0]           rd_addr_reg, rd_addr_next;
    logic                        out_valid_reg, out_valid_next;
    logic [irc_pkg::DIGIT_W-1:0] out_digit_reg, out_digit_next;
    logic                        out_last_reg, out_last_next;
    logic                        div_last;
    logic                        ram_we;
    logic                        ram_re;
    logic [irc_pkg::DIGIT_W-1:0] ram_rdata;

    always_comb
    begin
        priority if (cfg_wr_data < irc_pkg::RADIX_MIN)
        begin
            radix_next = irc_pkg::RADIX_MIN;
        end
        else if (cfg_wr_data > irc_pkg::RADIX_MAX)
        begin
            radix_next = irc_pkg::RADIX_MAX;
        end
        else
        begin
            radix_next = cfg_wr_data;
        end
    end

    always_comb
    begin
        logic [irc_pkg::DIGIT_W:0] trial;
        logic                      ge;
        quot_step = quot_reg;
        rem_step  = rem_reg;
        for (int i = 0; i < irc_pkg::STEP_BITS; i++)
        begin
            trial = {rem_step, quot_step[DIV_BITS-1]};
            ge    = (trial >= radix_reg);
            if (ge)
            begin
                trial = trial - radix_reg;
            end
            rem_step  = trial[irc_pkg::DIGIT_W-1:0];
            quot_step = {quot_step[DIV_BITS-2:0], ge};
        end
    end

    assign div_last  = (dcnt_reg == DCNT_W'(DIV_CYCLES - 1));
    assign count_dec = count_reg - CNT_W'(1);
    assign ram_we    = cmd.div_step && div_last;
    assign ram_re    = cmd.rd_start || cmd.rd_step;

    always_comb
    begin
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        count_next   = count_reg;
        rd_addr_next = rd_addr_reg;
        if (cmd.load)
        begin
            quot_next  = DIV_BITS'(in_value);
            rem_next   = '0;
            dcnt_next  = '0;
            count_next = '0;
        end
        else if (cmd.div_step)
        begin
            quot_next = quot_step;
            if (div_last)
            begin
                rem_next   = '0;
                dcnt_next  = '0;
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                rem_next  = rem_step;
                dcnt_next = dcnt_reg + DCNT_W'(1);
            end
        end
        if (cmd.rd_start)
        begin
            rd_addr_next = count_dec[ADDR_W-1:0];
        end
        else if (cmd.rd_step)
        begin
            rd_addr_next = rd_addr_reg - ADDR_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_digit_next = out_digit_reg;
        out_last_next  = out_last_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_digit_next = ram_rdata;
            out_last_next  = (rd_addr_reg == '0);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= irc_pkg::RADIX_RESET;
            dcnt_reg      <= '0;
            count_reg     <= '0;
            rd_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                radix_reg <= radix_next;
            end
            dcnt_reg      <= dcnt_next;
            count_reg     <= count_next;
            rd_addr_reg   <= rd_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        out_digit_reg <= out_digit_next;
        out_last_reg  <= out_last_next;
    end

    irc_ram #(
        .WIDTH (irc_pkg::DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digit_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (rem_step),
        .re    (ram_re),
        .raddr (rd_addr_next),
        .rdata (ram_rdata)
    );

    assign st.div_last  = div_last;
    assign st.quot_zero = (quot_step == '0);
    assign st.emit_last = (rd_addr_reg == '0);
    assign st.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_digit = out_digit_reg;
    assign out_last  = out_last_reg;

endmodule

// File: rtl/irc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_controller: sequencing state machine
// Steps through loading, division of each digit, and playback of the stored
// digits, and issues the datapath commands.
// ----------------------------------------------------------------------------
module irc_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  irc_pkg::status_t st,
    output irc_pkg::cmd_t    cmd
);

    irc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= irc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            irc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = irc_pkg::ST_DIVIDE;
                end
            end
            irc_pkg::ST_DIVIDE:
            begin
                if (st.div_last && st.quot_zero)
                begin
                    state_next = irc_pkg::ST_READ;
                end
            end
            irc_pkg::ST_READ:
            begin
                state_next = irc_pkg::ST_EMIT;
            end
            irc_pkg::ST_EMIT:
            begin
                if (st.out_free && st.emit_last)
                begin
                    state_next = irc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = irc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            irc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            irc_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            irc_pkg::ST_READ:
            begin
                cmd.rd_start = 1'b1;
            end
            irc_pkg::ST_EMIT:
            begin
                cmd.out_load = st.out_free;
                cmd.rd_step  = st.out_free && !st.emit_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/irc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_checker: port-level checks for the integer radix converter
// Watches the stream ports of the top level and flags sequencing faults.
// ----------------------------------------------------------------------------
module irc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [irc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Output word changed while stalled.");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[irc_pkg::OUT_TDATA_W-1:irc_pkg::DIGIT_W] == '0))
        else $error("Output word carries bits above the digit.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input accepted while a conversion is under way.");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
        else $error("Converter went idle without presenting a final digit.");

endmodule

bind integer_radix_converter_top irc_checker u_irc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for integer_radix_converter_top
// Streams unsigned values into the converter under several radix settings,
// predicts the digit words of each accepted value and checks every output word
// in order, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VALUE_BITS = 31;
    localparam int IN_W       = ((VALUE_BITS + 7) / 8) * 8;
    localparam int SHOWN_MAX  = 10;

    typedef struct packed {
        logic [irc_pkg::DIGIT_W-1:0] digit;
        logic                        last_digit;
    } digit_word_t;

    class digit_scoreboard;
        digit_word_t                 expected_digits[$];
        logic [irc_pkg::RADIX_W-1:0] radix_reg;
        int unsigned                 values_noted;
        int unsigned                 digits_checked;
        int unsigned                 failures;
        int unsigned                 longest_run;

        function new();
            radix_reg      = irc_pkg::RADIX_RESET;
            values_noted   = 0;
            digits_checked = 0;
            failures       = 0;
            longest_run    = 0;
        endfunction

        function void set_radix(logic [irc_pkg::RADIX_W-1:0] r);
            radix_reg = r;
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= SHOWN_MAX)
                $display("%0t: mismatch: %s", $time, msg);
        endfunction

        function void note_value(logic [IN_W-1:0] word);
            logic [VALUE_BITS-1:0] quotient;
            logic [VALUE_BITS-1:0] base;
            digit_word_t           run[$];
            digit_word_t           item;

            base = VALUE_BITS'(radix_reg);
            if (radix_reg < irc_pkg::RADIX_MIN)
                base = VALUE_BITS'(irc_pkg::RADIX_MIN);
            if (radix_reg > irc_pkg::RADIX_MAX)
                base = VALUE_BITS'(irc_pkg::RADIX_MAX);
            quotient = word[VALUE_BITS-1:0];
            do
            begin
                item.digit      = irc_pkg::DIGIT_W'(quotient % base);
                item.last_digit = 1'b0;
                run.push_front(item);
                quotient = quotient / base;
            end
            while (quotient != 0);
            run[run.size()-1].last_digit = 1'b1;
            if (run.size() > longest_run)
                longest_run = run.size();
            foreach (run[i])
                expected_digits.push_back(run[i]);
            values_noted++;
        endfunction

        function void check_digit(logic [irc_pkg::OUT_TDATA_W-1:0] data, logic last);
            digit_word_t want;

            digits_checked++;
            if (expected_digits.size() == 0)
            begin
                report($sformatf("unexpected word digit=%0d last=%0b",
                                 data[irc_pkg::DIGIT_W-1:0], last));
                return;
            end
            want = expected_digits.pop_front();
            if (data[irc_pkg::DIGIT_W-1:0] !== want.digit || last !== want.last_digit)
                report($sformatf("expected digit=%0d last=%0b, got digit=%0d last=%0b",
                                 want.digit, want.last_digit,
                                 data[irc_pkg::DIGIT_W-1:0], last));
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_valid = 1'b0;
    logic [IN_W-1:0]                    s_data = '0;
    logic                               m_ready = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [irc_pkg::RADIX_W-1:0]        cfg_wr_data = '0;
    logic                               s_axis_tready;
    logic                               m_axis_tvalid;
    logic [irc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                               m_axis_tlast;

    int                                 send_idle_pct = 19;
    int                                 recv_idle_pct = 72;
    int unsigned                        radix_writes = 0;
    digit_scoreboard                    sb = new();

    integer_radix_converter_top #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_ready)
            sb.check_digit(m_axis_tdata, m_axis_tlast);
    end

    initial
    begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic send_value(input logic [IN_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_valid = 1'b0;
            @(negedge clk);
        end
        s_valid = 1'b1;
        s_data  = word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_value(word);
        @(negedge clk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic set_radix(input logic [irc_pkg::RADIX_W-1:0] r);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = r;
        sb.set_radix(r);
        radix_writes++;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = irc_pkg::RADIX_W'($urandom);
    endtask

    function automatic logic [IN_W-1:0] pick_value();
        logic [IN_W-1:0] v;

        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = IN_W'($urandom);
            4, 5, 6:    v = IN_W'($urandom_range(0, 300));
            7:          v = IN_W'($urandom >> $urandom_range(0, 31));
            8:          v = IN_W'({VALUE_BITS{1'b1}}) | (IN_W'($urandom) & ~IN_W'({VALUE_BITS{1'b1}}));
            default:    v = IN_W'($urandom) & ~IN_W'({VALUE_BITS{1'b1}});
        endcase
        return v;
    endfunction

    initial
    begin
        logic [IN_W-1:0] all_ones;

        all_ones = IN_W'({VALUE_BITS{1'b1}});
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset radix first, then the extremes, the clamped settings, and radix 3 and 15.
        send_value(0);
        send_value(9);
        send_value(10);
        send_value(1234567890);
        send_value(all_ones);
        send_value(~all_ones);
        send_value('1);
        set_radix(2);
        send_value(0);
        send_value(1);
        send_value(all_ones);
        send_value(IN_W'(1) << (VALUE_BITS - 1));
        set_radix(16);
        send_value(15);
        send_value(16);
        send_value(all_ones);
        set_radix(0);
        send_value(6);
        set_radix(1);
        send_value(5);
        set_radix(17);
        send_value(255);
        set_radix(31);
        send_value(all_ones);
        set_radix(3);
        send_value(all_ones);
        set_radix(15);
        send_value(all_ones);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_radix(2);
                1:       set_radix(irc_pkg::RADIX_W'($urandom_range(0, 31)));
                2:       set_radix(16);
                3:       set_radix(irc_pkg::RADIX_W'($urandom_range(3, 15)));
                4:       set_radix(10);
                default: set_radix(irc_pkg::RADIX_W'($urandom_range(0, 31)));
            endcase
            if (phase < 2)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 72;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (25) send_value(pick_value());
        end

        drain();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected digits never arrived", sb.pending()));
        $display("Converted %0d values into %0d digit words under %0d radix writes.",
                 sb.values_noted, sb.digits_checked, radix_writes);
        $display("Longest digit run %0d, failures %0d.", sb.longest_run, sb.failures);
        if (sb.failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/irc_pkg.sv
rtl/irc_ram.sv
rtl/irc_datapath.sv
rtl/irc_controller.sv
rtl/integer_radix_converter_top.sv
rtl/irc_checker.sv
verif/testbench.sv
